[hdl/kcalc_pkg.sv]
`timescale 1ns / 1ps

package kcalc_pkg;

	// Keys accepted since the last clear before the next poll is forced to an error result
	localparam int unsigned MAX_KEYS = 32;
	localparam int unsigned KEY_COUNT_W = 6;
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned CODE_W = 7;

	// Key kinds
	localparam logic [2:0] K_NONE   = 3'd0;
	localparam logic [2:0] K_DIGIT  = 3'd1;
	localparam logic [2:0] K_PLUS   = 3'd2;
	localparam logic [2:0] K_MINUS  = 3'd3;
	localparam logic [2:0] K_TIMES  = 3'd4;
	localparam logic [2:0] K_EQUALS = 3'd5;
	localparam logic [2:0] K_CLEAR  = 3'd6;
	localparam logic [2:0] K_UNUSED = 3'd7;

	// Poll codes: a digit carries a tag above the key kinds
	localparam logic [CODE_W-1:0] NO_KEY_CODE = 7'h7F;
	localparam logic [2:0] DIGIT_TAG = 3'b001;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] digit;
	} key_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      is_error;
	} res_t;

endpackage

[hdl/kcalc_core.sv]
`timescale 1ns / 1ps

module kcalc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  kcalc_pkg::key_t   key_s1,
	output logic              res_strobe,
	output kcalc_pkg::res_t   res_next
);

	logic [kcalc_pkg::CODE_W-1:0]      last_key_q;
	logic [kcalc_pkg::KEY_COUNT_W-1:0] key_count_q;
	logic                              error_seen_q;
	logic                              after_operator_q;
	logic [kcalc_pkg::VALUE_W-1:0]     sum_of_terms_q;
	logic [kcalc_pkg::VALUE_W-1:0]     term_prefix_q;
	logic                              term_negative_q;
	logic [kcalc_pkg::VALUE_W-1:0]     operand_q;

	logic                              forced;
	logic [2:0]                        op_eff;
	logic [kcalc_pkg::CODE_W-1:0]      code;
	logic                              ignored;
	logic [2*kcalc_pkg::VALUE_W-1:0]   product_full;
	logic [kcalc_pkg::VALUE_W-1:0]     product;
	logic [kcalc_pkg::VALUE_W-1:0]     current_value;
	logic [kcalc_pkg::VALUE_W-1:0]     operand_next;
	logic [kcalc_pkg::KEY_COUNT_W-1:0] key_count_inc;
	logic                              result_error;

	assign forced = (key_count_q >= kcalc_pkg::KEY_COUNT_W'(kcalc_pkg::MAX_KEYS));
	assign op_eff = forced ? kcalc_pkg::K_EQUALS : key_s1.op;
	assign code = (op_eff == kcalc_pkg::K_DIGIT) ? {kcalc_pkg::DIGIT_TAG, key_s1.digit}
		: {4'b0000, op_eff};
	assign ignored = !forced && (op_eff == kcalc_pkg::K_NONE || op_eff == kcalc_pkg::K_UNUSED
		|| code == last_key_q);

	// One shared multiplier serves both the open term and a times key
	assign product_full = term_prefix_q * operand_q;
	assign product = product_full[kcalc_pkg::VALUE_W-1:0];
	assign current_value = term_negative_q ? (sum_of_terms_q - product)
		: (sum_of_terms_q + product);

	// operand * 10 + digit as shift-and-add, wrapping
	assign operand_next = {operand_q[kcalc_pkg::VALUE_W-4:0], 3'b000}
		+ {operand_q[kcalc_pkg::VALUE_W-2:0], 1'b0}
		+ {{(kcalc_pkg::VALUE_W-4){1'b0}}, key_s1.digit};
	assign key_count_inc = key_count_q + 1'b1;

	assign result_error = forced || error_seen_q;
	assign res_strobe = fire && !ignored && (op_eff == kcalc_pkg::K_EQUALS);
	assign res_next.is_error = result_error;
	assign res_next.value = (result_error || after_operator_q) ? '0 : current_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_key_q <= kcalc_pkg::NO_KEY_CODE;
			key_count_q <= '0;
			error_seen_q <= 1'b0;
			after_operator_q <= 1'b0;
			sum_of_terms_q <= '0;
			term_prefix_q <= kcalc_pkg::VALUE_W'(1);
			term_negative_q <= 1'b0;
			operand_q <= '0;
		end else if (fire) begin
			last_key_q <= code;
			if (!ignored) begin
				unique case (op_eff)
					kcalc_pkg::K_DIGIT: begin
						operand_q <= operand_next;
						after_operator_q <= 1'b0;
						key_count_q <= key_count_inc;
					end
					kcalc_pkg::K_PLUS, kcalc_pkg::K_MINUS, kcalc_pkg::K_TIMES: begin
						if (key_count_q == '0 || after_operator_q)
							error_seen_q <= 1'b1;
						if (op_eff == kcalc_pkg::K_TIMES) begin
							term_prefix_q <= product;
						end else begin
							sum_of_terms_q <= current_value;
							term_prefix_q <= kcalc_pkg::VALUE_W'(1);
							term_negative_q <= (op_eff == kcalc_pkg::K_MINUS);
						end
						operand_q <= '0;
						after_operator_q <= 1'b1;
						key_count_q <= key_count_inc;
					end
					kcalc_pkg::K_EQUALS, kcalc_pkg::K_CLEAR: begin
						// drop the expression
						key_count_q <= '0;
						error_seen_q <= 1'b0;
						after_operator_q <= 1'b0;
						sum_of_terms_q <= '0;
						term_prefix_q <= kcalc_pkg::VALUE_W'(1);
						term_negative_q <= 1'b0;
						operand_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= kcalc_pkg::KEY_COUNT_W'(kcalc_pkg::MAX_KEYS))
		else $error("key count beyond limit");

	a_forced_error: assert property (@(posedge clk) disable iff (!arst_n)
		fire && forced |-> res_strobe && res_next.is_error)
		else $error("long expression did not give an error result");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && res_next.is_error |-> res_next.value == '0)
		else $error("error result with non-zero value");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe |=> key_count_q == '0 && !error_seen_q && operand_q == '0)
		else $error("expression not cleared after result");

endmodule

[hdl/keypad_calculator_precedence_unit.sv]
`timescale 1ns / 1ps

// Channel   Direction  Payload            Transfer
// key       in         kcalc_pkg::key_t   key_valid high, key_stall low
// res       out        kcalc_pkg::res_t   res_valid high, res_stall low
//
// One poll per cycle while the result is not stalled: a poll is captured, then
// evaluated by the core (one 16x16 multiply and an add or subtract) when the
// result register is free, and an equals result is registered.
// arst_n clears the expression state, the last poll code and both valid flags.
// A stalled result holds the core; one further poll waits in the input register.

module keypad_calculator_precedence_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            key_valid,
	output logic            key_stall,
	input  kcalc_pkg::key_t key,
	output logic            res_valid,
	input  logic            res_stall,
	output kcalc_pkg::res_t res
);

	logic            s1_valid_q;
	kcalc_pkg::key_t key_s1;
	logic            res_valid_q;
	kcalc_pkg::res_t res_q;
	logic            fire;
	logic            res_strobe;
	kcalc_pkg::res_t res_next;

	// Evaluate the held poll once the result register is free or being emptied
	assign fire = s1_valid_q && (!res_valid_q || !res_stall);
	assign key_stall = s1_valid_q && !fire;
	assign res_valid = res_valid_q;
	assign res = res_q;

	kcalc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.key_s1     (key_s1),
		.res_strobe (res_strobe),
		.res_next   (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (!key_stall)
				s1_valid_q <= key_valid;
			if (fire)
				res_valid_q <= res_strobe;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (key_valid && !key_stall)
			key_s1 <= key;
		if (fire && res_strobe)
			res_q <= res_next;
	end

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		key_stall |-> s1_valid_q && res_valid_q)
		else $error("input stalled with nothing held");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_stall |=> res_valid_q && $stable(res_q))
		else $error("stalled result lost or changed");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_strobe |-> !res_valid_q || !res_stall)
		else $error("result register overwritten while stalled");

endmodule
